>>> rtl/core/bct_pkg.sv
// Package for the battery charge tracker.
// Field widths, reset values, event kind codes and the arithmetic unit command type.
// No dependencies.
`default_nettype none
package bct_pkg;

   localparam int OPA_W  = 51;
   localparam int OPB_W  = 33;
   localparam int RES_W  = 66;
   localparam int CNT_W  = 6;
   localparam int MUL_STEPS = 33;
   localparam int DIV_STEPS = 51;

   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_HEATER   = 2'd1;
   localparam logic [1:0] KIND_THERMAL  = 2'd2;
   localparam logic [1:0] KIND_OVERRIDE = 2'd3;

   localparam logic [2:0] CSR_SOLAR_FULL = 3'd0;
   localparam logic [2:0] CSR_BUS        = 3'd1;
   localparam logic [2:0] CSR_PAYLOAD    = 3'd2;
   localparam logic [2:0] CSR_SLEEP      = 3'd3;
   localparam logic [2:0] CSR_LOSS_RATE  = 3'd4;
   localparam logic [2:0] CSR_LOSS_GROW  = 3'd5;
   localparam logic [2:0] CSR_FULL_CAP   = 3'd6;
   localparam logic [2:0] CSR_MIN_CAP    = 3'd7;

   localparam logic [15:0] RST_SOLAR_FULL = 16'd1600;
   localparam logic [15:0] RST_BUS        = 16'd320;
   localparam logic [15:0] RST_PAYLOAD    = 16'd480;
   localparam logic [15:0] RST_SLEEP      = 16'd80;
   localparam logic [31:0] RST_LOSS_RATE  = 32'd429497;
   localparam logic [31:0] RST_LOSS_GROW  = 32'd4294967;
   localparam logic [31:0] RST_FULL_CAP   = 32'd92160000;
   localparam logic [31:0] RST_MIN_CAP    = 32'd2560000;

   localparam logic [16:0] Q16_ONE  = 17'd65536;
   localparam logic [16:0] Q16_HALF = 17'd32768;
   localparam logic [32:0] Q32_ONE  = 33'h1_0000_0000;
   localparam logic [32:0] ENERGY_DIV = 33'd125;
   localparam logic [16:0] DRAW_MAX = 17'h1FFFF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic start;
      logic is_div;
   } alu_cmd_type;

endpackage
`default_nettype wire

>>> rtl/core/bct_alu.sv
// Shared bit-serial arithmetic unit: shift-add multiply (33 steps) and
// restoring divide (51 steps), one bit per cycle. Depends on bct_pkg.
`default_nettype none
module bct_alu
   import bct_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire alu_cmd_type       cmd,
   input  wire logic [OPA_W-1:0]  opa,
   input  wire logic [OPB_W-1:0]  opb,
   output logic [RES_W-1:0]       result,
   output logic                   done
);

   logic             busy_ff;
   logic             div_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [RES_W-1:0] acc_ff;
   logic [32:0]      mcand_ff;
   logic [OPA_W-1:0] quo_ff;
   logic [32:0]      rem_ff;
   logic [31:0]      divisor_ff;

   logic [33:0] sum;
   logic [32:0] trial;
   logic        ge;
   logic        last;

   always_comb begin
      sum   = {1'b0, acc_ff[65:33]} + (acc_ff[0] ? {1'b0, mcand_ff} : 34'd0);
      trial = {rem_ff[31:0], quo_ff[OPA_W-1]};
      ge    = trial >= {1'b0, divisor_ff};
      last  = div_ff ? (cnt_ff == CNT_W'(DIV_STEPS - 1)) : (cnt_ff == CNT_W'(MUL_STEPS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            div_ff  <= cmd.is_div;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff     <= {33'd0, opb};
         mcand_ff   <= opa[32:0];
         quo_ff     <= opa;
         rem_ff     <= '0;
         divisor_ff <= opb[31:0];
      end else if (busy_ff) begin
         if (div_ff) begin
            rem_ff <= ge ? (trial - {1'b0, divisor_ff}) : trial;
            quo_ff <= {quo_ff[OPA_W-2:0], ge};
         end else begin
            acc_ff <= {sum, acc_ff[32:1]};
         end
      end
   end

   assign result = div_ff ? {{(RES_W-OPA_W){1'b0}}, quo_ff} : acc_ff;
   assign done   = done_ff;

endmodule
`default_nettype wire

>>> rtl/core/battery_charge_tracker.sv
// Battery state-of-charge tracker: one response per request, sequenced over a
// shared bit-serial multiply/divide unit (one bit per cycle). Each multiply takes
// 33 steps and each divide 51, plus launch and hand-back. A tick does more work
// when it completes a charge cycle and skips the level divide at zero capacity;
// thermal and capacity override requests run a single multiply; a heater request
// with zero power runs no arithmetic. One request is in flight at a time; a
// finished response waits in an output register while the next request is taken.
// Depends on bct_pkg and bct_alu.
`default_nettype none
module battery_charge_tracker
   import bct_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [0] eclipse flag, [17:1] panel_efficiency, [18] sleep mode, [19] payload enable,
   // [35:20] step_ms, [51:36] heater_power, [68:52] thermal_value,
   // [100:69] capacity_value, rest zero
   input  wire logic [103:0] req_tdata,
   // [1:0] kind
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [16:0] charge_fraction, [48:17] usable_capacity, [64:49] cycle_total,
   // [80:65] solar_now, [97:81] draw_now, [98] charging, [99] cycle_done, rest zero
   output logic [103:0]      rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_SOLAR  = 16'h0002,
      ST_NETMUL = 16'h0004,
      ST_SCALE  = 16'h0008,
      ST_STORE  = 16'h0010,
      ST_SUM    = 16'h0020,
      ST_CLAMP  = 16'h0040,
      ST_LEVEL  = 16'h0080,
      ST_POST   = 16'h0100,
      ST_RG     = 16'h0200,
      ST_HIC    = 16'h0400,
      ST_LOC    = 16'h0800,
      ST_LOSS   = 16'h1000,
      ST_BASE   = 16'h2000,
      ST_EFF    = 16'h4000,
      ST_DONE   = 16'h8000
   } state_type;

   state_type state_ff;
   logic      launch_ff;

   logic [15:0] sfp_ff, bus_ff, pay_ff, slp_ff;
   logic [31:0] rate_ff, grow_ff, fullcap_ff, mincap_ff;

   logic [1:0]  kind_ff;
   logic        ecl_ff, sleep_ff, payon_ff;
   logic [16:0] effin_ff;
   logic [15:0] ms_ff, heat_ff;

   logic [16:0] charge_ff;
   logic [31:0] base_ff, effcap_ff;
   logic [16:0] therm_ff;
   logic [15:0] solar_ff;
   logic [16:0] draw_ff;
   logic [15:0] count_ff;
   logic        was_ff, now_ff, cdone_ff;

   logic        neg_ff;
   logic [16:0] mag_ff;
   logic [32:0] msprod_ff;
   logic [43:0] delta_ff;
   logic [48:0] stored_ff;
   logic [50:0] e_ff;
   logic [47:0] lvl_ff;
   logic [31:0] rghi_ff, rglo_ff;
   logic [47:0] hic_ff;
   logic [15:0] loc_ff;
   logic [32:0] loss_ff;

   logic         rsp_valid_ff;
   logic [103:0] rsp_data_ff;

   alu_cmd_type      cmd;
   logic [OPA_W-1:0] opa;
   logic [OPB_W-1:0] opb;
   logic [RES_W-1:0] res;
   logic             res_done;

   logic [16:0] in_eff, in_therm;
   logic [31:0] in_cap;
   logic [15:0] solar_new;
   logic [16:0] draw_new;
   logic [17:0] draw_heat;
   logic [48:0] loss_sum;
   logic [50:0] e_top;
   logic        out_free;

   bct_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .result (res),
      .done   (res_done)
   );

   always_comb begin
      cmd.start  = launch_ff;
      cmd.is_div = (state_ff == ST_SCALE) || (state_ff == ST_LEVEL);
      opa = '0;
      opb = '0;
      unique case (state_ff)
         ST_SOLAR: begin
            opa = {35'd0, sfp_ff};
            opb = {16'd0, effin_ff};
         end
         ST_NETMUL: begin
            opa = {34'd0, mag_ff};
            opb = {17'd0, ms_ff};
         end
         ST_SCALE: begin
            opa = {1'b0, msprod_ff, 17'd0};
            opb = ENERGY_DIV;
         end
         ST_STORE: begin
            opa = {34'd0, charge_ff};
            opb = {1'b0, effcap_ff};
         end
         ST_LEVEL: begin
            opa = {3'd0, lvl_ff};
            opb = {1'b0, effcap_ff};
         end
         ST_RG: begin
            opa = {19'd0, rate_ff};
            opb = {1'b0, grow_ff};
         end
         ST_HIC: begin
            opa = {19'd0, rghi_ff};
            opb = {17'd0, count_ff};
         end
         ST_LOC: begin
            opa = {19'd0, rglo_ff};
            opb = {17'd0, count_ff};
         end
         ST_BASE: begin
            opa = {19'd0, base_ff};
            opb = Q32_ONE - loss_ff;
         end
         ST_EFF: begin
            opa = {19'd0, base_ff};
            opb = {16'd0, therm_ff};
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_comb begin
      in_eff   = req_tdata[17:1];
      in_therm = req_tdata[68:52];
      in_cap   = req_tdata[100:69];
      if (in_therm < Q16_HALF) in_therm = Q16_HALF;
      if (in_therm > Q16_ONE) in_therm = Q16_ONE;
      if (in_cap < mincap_ff) in_cap = mincap_ff;
      if (in_cap > fullcap_ff) in_cap = fullcap_ff;
      if (in_eff > Q16_ONE) in_eff = Q16_ONE;
      solar_new = ecl_ff ? 16'd0 : res[31:16];
      draw_new  = sleep_ff ? {1'b0, slp_ff}
                           : ({1'b0, bus_ff} + (payon_ff ? {1'b0, pay_ff} : 17'd0));
      draw_heat = {1'b0, draw_ff} + {2'b0, heat_ff};
      loss_sum  = {17'd0, rate_ff} + {1'b0, hic_ff} + {33'd0, loc_ff};
      e_top     = {3'd0, effcap_ff, 16'd0};
      out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sfp_ff     <= RST_SOLAR_FULL;
         bus_ff     <= RST_BUS;
         pay_ff     <= RST_PAYLOAD;
         slp_ff     <= RST_SLEEP;
         rate_ff    <= RST_LOSS_RATE;
         grow_ff    <= RST_LOSS_GROW;
         fullcap_ff <= RST_FULL_CAP;
         mincap_ff  <= RST_MIN_CAP;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SOLAR_FULL: sfp_ff     <= csr_wdata[15:0];
            CSR_BUS:        bus_ff     <= csr_wdata[15:0];
            CSR_PAYLOAD:    pay_ff     <= csr_wdata[15:0];
            CSR_SLEEP:      slp_ff     <= csr_wdata[15:0];
            CSR_LOSS_RATE:  rate_ff    <= csr_wdata;
            CSR_LOSS_GROW:  grow_ff    <= csr_wdata;
            CSR_FULL_CAP:   fullcap_ff <= csr_wdata;
            CSR_MIN_CAP:    mincap_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         charge_ff    <= Q16_ONE;
         base_ff      <= RST_FULL_CAP;
         effcap_ff    <= RST_FULL_CAP;
         therm_ff     <= Q16_ONE;
         solar_ff     <= '0;
         draw_ff      <= '0;
         count_ff     <= '0;
         was_ff       <= 1'b1;
         cdone_ff     <= 1'b0;
      end else begin
         launch_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  cdone_ff <= 1'b0;
                  unique case (req_tuser)
                     KIND_TICK: begin
                        state_ff  <= ST_SOLAR;
                        launch_ff <= 1'b1;
                     end
                     KIND_HEATER: begin
                        neg_ff <= 1'b1;
                        mag_ff <= {1'b0, req_tdata[51:36]};
                        if (req_tdata[51:36] != 16'd0) begin
                           state_ff  <= ST_NETMUL;
                           launch_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     KIND_THERMAL: begin
                        therm_ff  <= in_therm;
                        state_ff  <= ST_EFF;
                        launch_ff <= 1'b1;
                     end
                     default: begin
                        base_ff   <= in_cap;
                        state_ff  <= ST_EFF;
                        launch_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_SOLAR: begin
               if (res_done) begin
                  solar_ff  <= solar_new;
                  draw_ff   <= draw_new;
                  now_ff    <= {1'b0, solar_new} > draw_new;
                  neg_ff    <= draw_new > {1'b0, solar_new};
                  mag_ff    <= (draw_new > {1'b0, solar_new}) ? (draw_new - {1'b0, solar_new})
                                                             : ({1'b0, solar_new} - draw_new);
                  state_ff  <= ST_NETMUL;
                  launch_ff <= 1'b1;
               end
            end
            ST_NETMUL: begin
               if (res_done) begin
                  msprod_ff <= res[32:0];
                  state_ff  <= ST_SCALE;
                  launch_ff <= 1'b1;
               end
            end
            ST_SCALE: begin
               if (res_done) begin
                  delta_ff  <= res[43:0];
                  state_ff  <= ST_STORE;
                  launch_ff <= 1'b1;
               end
            end
            ST_STORE: begin
               if (res_done) begin
                  stored_ff <= res[48:0];
                  state_ff  <= ST_SUM;
               end
            end
            ST_SUM: begin
               e_ff     <= neg_ff ? ({2'd0, stored_ff} - {7'd0, delta_ff})
                                  : ({2'd0, stored_ff} + {7'd0, delta_ff});
               state_ff <= ST_CLAMP;
            end
            ST_CLAMP: begin
               if (effcap_ff == 32'd0) begin
                  charge_ff <= '0;
                  state_ff  <= ST_POST;
               end else begin
                  if (e_ff[50]) lvl_ff <= '0;
                  else if (e_ff > e_top) lvl_ff <= e_top[47:0];
                  else lvl_ff <= e_ff[47:0];
                  state_ff  <= ST_LEVEL;
                  launch_ff <= 1'b1;
               end
            end
            ST_LEVEL: begin
               if (res_done) begin
                  charge_ff <= res[16:0];
                  state_ff  <= ST_POST;
               end
            end
            ST_POST: begin
               if (kind_ff == KIND_HEATER) begin
                  draw_ff  <= draw_heat[17] ? DRAW_MAX : draw_heat[16:0];
                  state_ff <= ST_DONE;
               end else begin
                  was_ff <= now_ff;
                  if (was_ff && !now_ff) begin
                     if (count_ff != COUNT_MAX) count_ff <= count_ff + 1'b1;
                     cdone_ff  <= 1'b1;
                     state_ff  <= ST_RG;
                     launch_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_RG: begin
               if (res_done) begin
                  rghi_ff   <= res[63:32];
                  rglo_ff   <= res[31:0];
                  state_ff  <= ST_HIC;
                  launch_ff <= 1'b1;
               end
            end
            ST_HIC: begin
               if (res_done) begin
                  hic_ff    <= res[47:0];
                  state_ff  <= ST_LOC;
                  launch_ff <= 1'b1;
               end
            end
            ST_LOC: begin
               if (res_done) begin
                  loc_ff   <= res[47:32];
                  state_ff <= ST_LOSS;
               end
            end
            ST_LOSS: begin
               loss_ff   <= (loss_sum > {16'd0, Q32_ONE}) ? Q32_ONE : loss_sum[32:0];
               state_ff  <= ST_BASE;
               launch_ff <= 1'b1;
            end
            ST_BASE: begin
               if (res_done) begin
                  base_ff   <= res[63:32];
                  state_ff  <= ST_EFF;
                  launch_ff <= 1'b1;
               end
            end
            ST_EFF: begin
               if (res_done) begin
                  effcap_ff <= res[47:16];
                  state_ff  <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {4'd0, cdone_ff, was_ff, draw_ff, solar_ff, count_ff,
                                   effcap_ff, charge_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff  <= req_tuser;
         ecl_ff   <= req_tdata[0];
         effin_ff <= in_eff;
         sleep_ff <= req_tdata[18];
         payon_ff <= req_tdata[19];
         ms_ff    <= req_tdata[35:20];
         heat_ff  <= req_tdata[51:36];
      end
   end

endmodule
`default_nettype wire
